>>> design/eecc_pkg.sv
// package for the event electron count combiner
// holds field widths, op codes, register indexes, the controller state, command and status types and the 2^x table
// no dependencies
package eecc_pkg;

    localparam int REG_W      = 20;
    localparam int AMT_W      = 16;
    localparam int CNT_W      = 4;
    localparam int EST_W      = 10;
    localparam int NUM_W      = 5;
    localparam int IDX_W      = 3;
    localparam int FRAC_W     = 8;
    localparam int DEF_PEAK_COUNT  = 3;
    localparam int DEF_MAX_OBJECTS = 15;

    localparam logic [1:0] OP_CLUSTER = 2'd0;
    localparam logic [1:0] OP_TRACK   = 2'd1;
    localparam logic [1:0] OP_END     = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [IDX_W-1:0] REG_EPEAK1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_EPEAK2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_EPEAK3 = 3'd2;
    localparam logic [IDX_W-1:0] REG_LPEAK1 = 3'd3;
    localparam logic [IDX_W-1:0] REG_LPEAK2 = 3'd4;
    localparam logic [IDX_W-1:0] REG_LPEAK3 = 3'd5;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    // controller commands to the datapath
    typedef struct packed {
        logic accumulate;
        logic setup;
        logic div_step;
        logic finish;
        logic load_out;
        logic clear;
    } cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic div_done;
    } status_t;

    // 2^(f/256)-1 in q8 from a bit-serial product of q2.30 constants for 2^(2^(b-8));
    // only evaluated on constants to build the lookup table
    function automatic logic [FRAC_W-1:0] pow2m1(input logic [FRAC_W-1:0] f);
        logic [63:0] r;
        logic [63:0] c;
        logic [63:0] g;
        r = 64'd1073741824;
        for (int b = FRAC_W - 1; b >= 0; b--) begin
            case (b)
                0: c = 64'd1076653033;
                1: c = 64'd1079572136;
                2: c = 64'd1085434106;
                3: c = 64'd1097253708;
                4: c = 64'd1121280435;
                5: c = 64'd1170923762;
                6: c = 64'd1276901417;
                default: c = 64'd1518500250;
            endcase
            if (f[b]) r = (r * c + 64'd536870912) >> 30;
        end
        g = (r - 64'd1073741824 + 64'd2097152) >> 22;
        return g[FRAC_W-1:0];
    endfunction

    // 256-entry 2^x-1 table, entry i at bits [i*8 +: 8]
    function automatic logic [256*FRAC_W-1:0] pow2m1_table();
        logic [256*FRAC_W-1:0] t;
        t = '0;
        for (int i = 0; i < 256; i++)
            t[i*FRAC_W +: FRAC_W] = pow2m1(FRAC_W'(i));
        return t;
    endfunction

endpackage

>>> design/eecc_ctrl.sv
// controller for the event electron count combiner
// sequences accumulation, the two shared-step divisions and the result handoff; uses eecc_pkg
module eecc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    output logic              m_valid,
    input  logic              m_ready,
    input  eecc_pkg::status_t status,
    output eecc_pkg::cmd_t    cmd
);
    import eecc_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    // state and output flag registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (s_op == OP_END) begin
                        state_next = ST_SETUP;
                    end else begin
                        cmd.accumulate = 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                // wait for the output register to be free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // end of event never leaves a result pending twice
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request taken while busy");
    a_setup_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_END) |=> state_reg == ST_SETUP)
        else $error("end of event not started");
endmodule

>>> design/eecc_datapath.sv
// datapath for the event electron count combiner
// sums, counters, peak registers, two restoring dividers and the combine logic; uses eecc_pkg
module eecc_datapath #(
    parameter int PEAK_COUNT  = eecc_pkg::DEF_PEAK_COUNT,
    parameter int MAX_OBJECTS = eecc_pkg::DEF_MAX_OBJECTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  eecc_pkg::cmd_t                 cmd,
    output eecc_pkg::status_t              status,
    input  logic [1:0]                     s_op,
    input  logic [eecc_pkg::AMT_W-1:0]     s_amount,
    input  logic                           cfg_write,
    input  logic [eecc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [eecc_pkg::REG_W-1:0]     cfg_data,
    output logic [eecc_pkg::NUM_W-1:0]     m_electron_count,
    output logic [eecc_pkg::CNT_W-1:0]     m_track_count,
    output logic [eecc_pkg::CNT_W-1:0]     m_cluster_count,
    output logic [eecc_pkg::EST_W-1:0]     m_energy_estimate,
    output logic [eecc_pkg::EST_W-1:0]     m_light_estimate
);
    import eecc_pkg::*;

    localparam int LIMIT_I = (MAX_OBJECTS > 15) ? 15 : MAX_OBJECTS;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LIMIT_I);
    localparam int NP = (PEAK_COUNT > 3) ? 3 : PEAK_COUNT;
    localparam logic [1:0] NPK = 2'(NP);
    localparam logic [256*FRAC_W-1:0] POW_TBL = pow2m1_table();

    logic [REG_W-1:0] epeak_reg [3];
    logic [REG_W-1:0] lpeak_reg [3];
    logic [REG_W-1:0] esum_reg, lsum_reg;
    logic [CNT_W-1:0] ccnt_reg, tcnt_reg;

    // peak registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epeak_reg[0] <= REG_W'(4000);
            epeak_reg[1] <= REG_W'(8000);
            epeak_reg[2] <= REG_W'(12000);
            lpeak_reg[0] <= REG_W'(1600);
            lpeak_reg[1] <= REG_W'(3200);
            lpeak_reg[2] <= REG_W'(4800);
        end else if (cfg_write) begin
            case (cfg_index)
                REG_EPEAK1: epeak_reg[0] <= cfg_data;
                REG_EPEAK2: epeak_reg[1] <= cfg_data;
                REG_EPEAK3: epeak_reg[2] <= cfg_data;
                REG_LPEAK1: lpeak_reg[0] <= cfg_data;
                REG_LPEAK2: lpeak_reg[1] <= cfg_data;
                REG_LPEAK3: lpeak_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturating sums and counts
    logic [REG_W:0] esum_add, lsum_add;
    assign esum_add = {1'b0, esum_reg} + (REG_W+1)'(s_amount);
    assign lsum_add = {1'b0, lsum_reg} + (REG_W+1)'(s_amount);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            esum_reg <= '0;
            lsum_reg <= '0;
            ccnt_reg <= '0;
            tcnt_reg <= '0;
        end else if (cmd.accumulate) begin
            if (s_op == OP_CLUSTER) begin
                esum_reg <= esum_add[REG_W] ? '1 : esum_add[REG_W-1:0];
                if (ccnt_reg < LIMIT) ccnt_reg <= ccnt_reg + 1'b1;
            end else if (s_op == OP_TRACK) begin
                lsum_reg <= lsum_add[REG_W] ? '1 : lsum_add[REG_W-1:0];
                if (tcnt_reg < LIMIT) tcnt_reg <= tcnt_reg + 1'b1;
            end
        end
    end

    // peak search for one sum
    function automatic logic [1:0] peak_k(input logic [REG_W-1:0] s,
                                          input logic [REG_W-1:0] p0,
                                          input logic [REG_W-1:0] p1,
                                          input logic [REG_W-1:0] p2);
        logic [1:0] k;
        k = 2'd0;
        if (NP >= 1 && s >= p0) begin
            k = 2'd1;
            if (NP >= 2 && s >= p1) begin
                k = 2'd2;
                if (NP >= 3 && s >= p2) k = 2'd3;
            end
        end
        return k;
    endfunction

    logic [1:0] ek, lk;
    assign ek = peak_k(esum_reg, epeak_reg[0], epeak_reg[1], epeak_reg[2]);
    assign lk = peak_k(lsum_reg, lpeak_reg[0], lpeak_reg[1], lpeak_reg[2]);

    // division registers: remainder, divisor, quotient bits and step count
    logic [1:0]       ek_reg, lk_reg;
    logic [REG_W:0]   erem_reg, lrem_reg;
    logic [REG_W-1:0] eden_reg, lden_reg;
    logic [FRAC_W:0]  eq_reg, lq_reg;
    logic [3:0]       step_reg;

    logic [REG_W-1:0] elo, ehi, llo, lhi;
    always_comb begin
        elo = '0; ehi = '0; llo = '0; lhi = '0;
        case (ek)
            2'd1: begin elo = epeak_reg[0]; ehi = epeak_reg[1]; end
            2'd2: begin elo = epeak_reg[1]; ehi = epeak_reg[2]; end
            default: ;
        endcase
        case (lk)
            2'd1: begin llo = lpeak_reg[0]; lhi = lpeak_reg[1]; end
            2'd2: begin llo = lpeak_reg[1]; lhi = lpeak_reg[2]; end
            default: ;
        endcase
    end

    // restoring division steps; quotient of (sum-lo)*256/(hi-lo), nine bits then clamp
    logic [REG_W+1:0] etry, ltry;
    assign etry = {erem_reg, 1'b0} - {2'b0, eden_reg};
    assign ltry = {lrem_reg, 1'b0} - {2'b0, lden_reg};

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            ek_reg   <= ek;
            lk_reg   <= lk;
            erem_reg <= {1'b0, esum_reg - elo};
            lrem_reg <= {1'b0, lsum_reg - llo};
            eden_reg <= ehi - elo;
            lden_reg <= lhi - llo;
            eq_reg   <= '0;
            lq_reg   <= '0;
            step_reg <= '0;
        end else if (cmd.div_step) begin
            step_reg <= step_reg + 1'b1;
            // remainder < divisor after step 0 check; first step tests quotient
            // overflow bit by comparing remainder directly
            if (step_reg == 4'd0) begin
                if (erem_reg >= {1'b0, eden_reg}) begin
                    eq_reg   <= {eq_reg[FRAC_W-1:0], 1'b1};
                    erem_reg <= erem_reg - {1'b0, eden_reg};
                end else eq_reg <= {eq_reg[FRAC_W-1:0], 1'b0};
                if (lrem_reg >= {1'b0, lden_reg}) begin
                    lq_reg   <= {lq_reg[FRAC_W-1:0], 1'b1};
                    lrem_reg <= lrem_reg - {1'b0, lden_reg};
                end else lq_reg <= {lq_reg[FRAC_W-1:0], 1'b0};
            end else begin
                if (!etry[REG_W+1]) begin
                    eq_reg   <= {eq_reg[FRAC_W-1:0], 1'b1};
                    erem_reg <= etry[REG_W:0];
                end else begin
                    eq_reg   <= {eq_reg[FRAC_W-1:0], 1'b0};
                    erem_reg <= {erem_reg[REG_W-1:0], 1'b0};
                end
                if (!ltry[REG_W+1]) begin
                    lq_reg   <= {lq_reg[FRAC_W-1:0], 1'b1};
                    lrem_reg <= ltry[REG_W:0];
                end else begin
                    lq_reg   <= {lq_reg[FRAC_W-1:0], 1'b0};
                    lrem_reg <= {lrem_reg[REG_W-1:0], 1'b0};
                end
            end
        end
    end

    assign status.div_done = (step_reg == 4'(FRAC_W));

    // estimates from peak index and clamped fraction, 2^x-1 by table lookup
    function automatic logic [EST_W-1:0] est(input logic [1:0] k,
                                             input logic [FRAC_W:0] q,
                                             input logic [REG_W-1:0] den,
                                             input logic [CNT_W-1:0] seen);
        logic [FRAC_W-1:0] f;
        logic [EST_W-1:0]  v;
        f = (den == '0) ? '0 : (q[FRAC_W] ? '1 : q[FRAC_W-1:0]);
        if (k == NPK) v = {NPK, {FRAC_W{1'b0}}};
        else if (k == 2'd0) v = (seen != '0) ? EST_W'(256) : '0;
        else v = {k, POW_TBL[{f, 3'b000} +: FRAC_W]};
        return v;
    endfunction

    logic [EST_W-1:0] e_reg, l_reg;
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            e_reg <= est(ek_reg, eq_reg, eden_reg, ccnt_reg);
            l_reg <= est(lk_reg, lq_reg, lden_reg, tcnt_reg);
        end
    end

    // combination rules
    logic signed [12:0] es, ls, t256;
    logic [CNT_W-1:0]   re, rl;
    logic [EST_W:0]     e_rnd, l_rnd;
    logic [NUM_W-1:0]   num;
    assign es    = 13'(e_reg);
    assign ls    = 13'(l_reg);
    assign t256  = 13'({tcnt_reg, 8'd0});
    assign e_rnd = (EST_W+1)'(e_reg) + 11'd128;
    assign l_rnd = (EST_W+1)'(l_reg) + 11'd128;
    assign re    = CNT_W'(e_rnd[EST_W:FRAC_W]);
    assign rl    = CNT_W'(l_rnd[EST_W:FRAC_W]);

    always_comb begin
        if (tcnt_reg == '0 && ccnt_reg == '0)
            num = (e_reg != '0 || l_reg != '0) ? NUM_W'(1) : '0;
        else if (tcnt_reg == ccnt_reg)
            num = (es - t256 > 13'sd512 && ls - t256 > 13'sd768)
                ? NUM_W'(tcnt_reg) + 1'b1 : NUM_W'(tcnt_reg);
        else if (tcnt_reg == '0)
            num = NUM_W'((re < ccnt_reg) ? re : ccnt_reg);
        else if (ccnt_reg == '0)
            num = NUM_W'(tcnt_reg);
        else if (tcnt_reg < ccnt_reg)
            num = (es - t256 > 13'sd512 && ls - t256 > 13'sd512)
                ? NUM_W'(tcnt_reg) + 1'b1 : NUM_W'(tcnt_reg);
        else
            num = (tcnt_reg > re || tcnt_reg > rl)
                ? NUM_W'(tcnt_reg) - 1'b1 : NUM_W'(tcnt_reg);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_electron_count  <= num;
            m_track_count     <= tcnt_reg;
            m_cluster_count   <= ccnt_reg;
            m_energy_estimate <= e_reg;
            m_light_estimate  <= l_reg;
        end
    end

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (ccnt_reg <= LIMIT) && (tcnt_reg <= LIMIT))
        else $error("count above limit");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (esum_reg == '0 && lsum_reg == '0 && ccnt_reg == '0))
        else $error("state not cleared");
    a_est_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.finish) |-> (e_reg <= EST_W'(768) && l_reg <= EST_W'(768)))
        else $error("estimate out of range");
endmodule

>>> design/event_electron_count_combiner_top.sv
// Event electron count combiner. Cluster and track requests are taken one per cycle and
// only add to sums and counters. An end of event request runs through a setup state, nine
// steps of the shared restoring divider pair (both estimates divide side by side, one
// quotient bit a step), a finish state for the 2^x table and an output state that loads
// the output register, which waits as long as an earlier result is still held by m_ready
// low; no request is taken meanwhile. Peak registers are to be written on the cfg port only
// while the block is idle; the block itself does not enforce it.
// top level; instantiates eecc_ctrl and eecc_datapath, uses eecc_pkg
module event_electron_count_combiner_top #(
    parameter int PEAK_COUNT  = eecc_pkg::DEF_PEAK_COUNT,
    parameter int MAX_OBJECTS = eecc_pkg::DEF_MAX_OBJECTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [eecc_pkg::AMT_W-1:0]    s_amount,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [eecc_pkg::NUM_W-1:0]    m_electron_count,
    output logic [eecc_pkg::CNT_W-1:0]    m_track_count,
    output logic [eecc_pkg::CNT_W-1:0]    m_cluster_count,
    output logic [eecc_pkg::EST_W-1:0]    m_energy_estimate,
    output logic [eecc_pkg::EST_W-1:0]    m_light_estimate,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [eecc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [eecc_pkg::REG_W-1:0]    cfg_data
);
    import eecc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    eecc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    eecc_datapath #(
        .PEAK_COUNT  (PEAK_COUNT),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_op              (s_op),
        .s_amount          (s_amount),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_electron_count  (m_electron_count),
        .m_track_count     (m_track_count),
        .m_cluster_count   (m_cluster_count),
        .m_energy_estimate (m_energy_estimate),
        .m_light_estimate  (m_light_estimate)
    );
endmodule

>>> tb/sv/eecc_checker.sv
// checker for the event electron count combiner: watches request, result and cfg channels
// predicts each end-of-event result and compares it field by field
// depends on eecc_pkg
module eecc_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [eecc_pkg::AMT_W-1:0] s_amount,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [eecc_pkg::NUM_W-1:0] m_electron_count,
    input  logic [eecc_pkg::CNT_W-1:0] m_track_count,
    input  logic [eecc_pkg::CNT_W-1:0] m_cluster_count,
    input  logic [eecc_pkg::EST_W-1:0] m_energy_estimate,
    input  logic [eecc_pkg::EST_W-1:0] m_light_estimate,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [eecc_pkg::IDX_W-1:0] cfg_index,
    input  logic [eecc_pkg::REG_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending_events
);
    timeunit 1ns;
    timeprecision 1ps;
    import eecc_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0] electrons;
        logic [CNT_W-1:0] tracks;
        logic [CNT_W-1:0] clusters;
        logic [EST_W-1:0] e_est;
        logic [EST_W-1:0] l_est;
    } event_result_t;

    localparam logic [REG_W-1:0] SUM_SAT = '1;
    localparam int CNT_LIMIT = (DEF_MAX_OBJECTS > 15) ? 15 : DEF_MAX_OBJECTS;

    logic [REG_W-1:0] e_peak [3];
    logic [REG_W-1:0] l_peak [3];
    logic [REG_W-1:0] e_total, l_total;
    int               n_clusters, n_tracks;
    int               fails = 0;
    event_result_t    expected_events [$];

    assign pending_events = expected_events.size();
    assign fail_count = fails;

    // 2^(f/256)-1 in q8, bit-serial product of q2.30 constants
    function automatic int exp2_frac(input int f);
        longint unsigned r;
        longint unsigned k [8];
        k = '{1076653033, 1079572136, 1085434106, 1097253708,
              1121280435, 1170923762, 1276901417, 1518500250};
        r = 64'd1073741824;
        for (int b = 7; b >= 0; b--)
            if (f[b]) r = (r * k[b] + 64'd536870912) >> 30;
        return int'((r - 64'd1073741824 + 64'd2097152) >> 22);
    endfunction

    // fractional electron estimate from one sum against its peaks
    function automatic int peak_estimate(input longint unsigned total,
                                         input longint unsigned p0, p1, p2, input int seen);
        longint unsigned pk [3];
        longint unsigned num, den, f;
        int k;
        pk = '{p0, p1, p2};
        k = 0;
        while (k < 3 && total >= pk[k]) k++;
        if (k == 3) return 768;
        if (k == 0) return (seen != 0) ? 256 : 0;
        den = pk[k] - pk[k-1];
        num = (total - pk[k-1]) << 8;
        f = (den != 0) ? num / den : 0;
        if (f > 255) f = 255;
        return k * 256 + exp2_frac(int'(f));
    endfunction

    // agreement rules over track and cluster counts and both estimates
    function automatic int electrons_from(input int t, c, e, l);
        int re, rl;
        re = (e + 128) >>> 8;
        rl = (l + 128) >>> 8;
        if (t == 0 && c == 0) return (e != 0 || l != 0) ? 1 : 0;
        if (t == c) return (e - 256*t > 512 && l - 256*t > 768) ? t + 1 : t;
        if (t == 0) return (re < c) ? re : c;
        if (c == 0) return t;
        if (t < c) return (e - 256*t > 512 && l - 256*t > 512) ? t + 1 : t;
        return (t > re || t > rl) ? t - 1 : t;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // predict on accepted requests and cfg writes
    always @(posedge aclk) begin
        event_result_t r;
        int e, l;
        logic [REG_W:0] s;
        if (!aresetn) begin
            e_peak = '{20'd4000, 20'd8000, 20'd12000};
            l_peak = '{20'd1600, 20'd3200, 20'd4800};
            e_total = '0; l_total = '0; n_clusters = 0; n_tracks = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_EPEAK1: e_peak[0] = cfg_data;
                    REG_EPEAK2: e_peak[1] = cfg_data;
                    REG_EPEAK3: e_peak[2] = cfg_data;
                    REG_LPEAK1: l_peak[0] = cfg_data;
                    REG_LPEAK2: l_peak[1] = cfg_data;
                    REG_LPEAK3: l_peak[2] = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_op)
                    OP_CLUSTER: begin
                        s = {1'b0, e_total} + (REG_W+1)'(s_amount);
                        e_total = s[REG_W] ? SUM_SAT : s[REG_W-1:0];
                        if (n_clusters < CNT_LIMIT) n_clusters++;
                    end
                    OP_TRACK: begin
                        s = {1'b0, l_total} + (REG_W+1)'(s_amount);
                        l_total = s[REG_W] ? SUM_SAT : s[REG_W-1:0];
                        if (n_tracks < CNT_LIMIT) n_tracks++;
                    end
                    OP_END: begin
                        e = peak_estimate(e_total, e_peak[0], e_peak[1], e_peak[2], n_clusters);
                        l = peak_estimate(l_total, l_peak[0], l_peak[1], l_peak[2], n_tracks);
                        r.electrons = NUM_W'(electrons_from(n_tracks, n_clusters, e, l));
                        r.tracks = CNT_W'(n_tracks);
                        r.clusters = CNT_W'(n_clusters);
                        r.e_est = EST_W'(e);
                        r.l_est = EST_W'(l);
                        expected_events.insert(expected_events.size(), r);
                        e_total = '0; l_total = '0; n_clusters = 0; n_tracks = 0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // compare accepted results against the oldest prediction
    always @(posedge aclk) begin
        event_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                fails++;
            end else begin
                w = expected_events.pop_front();
                if (m_electron_count !== w.electrons)
                    report_mismatch("electron_count", int'(m_electron_count),
                                    int'(w.electrons));
                if (m_track_count !== w.tracks)
                    report_mismatch("track_count", int'(m_track_count), int'(w.tracks));
                if (m_cluster_count !== w.clusters)
                    report_mismatch("cluster_count", int'(m_cluster_count),
                                    int'(w.clusters));
                if (m_energy_estimate !== w.e_est)
                    report_mismatch("energy_estimate", int'(m_energy_estimate),
                                    int'(w.e_est));
                if (m_light_estimate !== w.l_est)
                    report_mismatch("light_estimate", int'(m_light_estimate),
                                    int'(w.l_est));
            end
        end
    end
endmodule

>>> tb/sv/tb_top.sv
// testbench top for the event electron count combiner: clock, reset, stimulus and verdict
// depends on eecc_pkg, event_electron_count_combiner_top and eecc_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import eecc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_op = OP_CLUSTER;
    logic [AMT_W-1:0]    s_amount = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [NUM_W-1:0]    m_electron_count;
    logic [CNT_W-1:0]    m_track_count, m_cluster_count;
    logic [EST_W-1:0]    m_energy_estimate, m_light_estimate;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [REG_W-1:0]    cfg_data = '0;
    int                  fail_count, pending_events;
    int                  idle_pct = 17;
    bit                  hold_results = 1'b0;
    int                  quiet_cycles = 0;

    event_electron_count_combiner_top DUT (.*);
    eecc_checker u_checker (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // receiver readiness: random idling plus optional long hold-off
    always @(posedge aclk) begin
        m_ready <= !hold_results && ($urandom_range(99) >= idle_pct);
    end

    // watchdog on cycles with no accepted traffic
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // one request on the input channel, with random lead gap; valid stays high
    // after acceptance so back to back requests need no second assignment
    task automatic send_request(input logic [1:0] op, input logic [AMT_W-1:0] amt);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_amount <= amt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for all results, then let the end-of-event pipeline drain
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_events != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_peaks(input logic [REG_W-1:0] e0, e1, e2, l0, l1, l2);
        drain_results();
        write_reg(REG_EPEAK1, e0);
        write_reg(REG_EPEAK2, e1);
        write_reg(REG_EPEAK3, e2);
        write_reg(REG_LPEAK1, l0);
        write_reg(REG_LPEAK2, l1);
        write_reg(REG_LPEAK3, l2);
    endtask

    // one event of random content; mostly small, sometimes many objects
    task automatic random_event(input int amt_max);
        int nc, nt;
        nc = ($urandom_range(9) == 0) ? int'($urandom_range(20)) : int'($urandom_range(4));
        nt = ($urandom_range(9) == 0) ? int'($urandom_range(20)) : int'($urandom_range(4));
        while (nc + nt > 0) begin
            if ($urandom_range(30) == 0)
                send_request(OP_UNUSED, AMT_W'($urandom));
            else if (nc > 0 && (nt == 0 || $urandom_range(1))) begin
                send_request(OP_CLUSTER, AMT_W'($urandom_range(amt_max)));
                nc--;
            end else begin
                send_request(OP_TRACK, AMT_W'($urandom_range(amt_max)));
                nt--;
            end
        end
        send_request(OP_END, AMT_W'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty event, extremes, unused op, saturation
        send_request(OP_END, '0);
        send_request(OP_CLUSTER, '1);
        send_request(OP_END, '1);
        send_request(OP_TRACK, 16'd0);
        send_request(OP_END, '0);
        send_request(OP_UNUSED, '1);
        send_request(OP_END, '0);
        repeat (16) send_request(OP_CLUSTER, '1);
        repeat (17) send_request(OP_TRACK, '1);
        send_request(OP_END, '0);
        send_request(OP_CLUSTER, 16'd5000);
        send_request(OP_TRACK, 16'd2000);
        send_request(OP_END, '0);

        // sender pause until every result is back
        drain_results();

        // receiver long hold-off while requests keep coming
        hold_results = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_results = 1'b0;
            end
            repeat (6) random_event(20000);
        join

        // random events under reset peaks, with a stretch of no idling
        for (int i = 0; i < 25; i++) random_event(6000);
        idle_pct = 0;
        for (int i = 0; i < 20; i++) random_event(6000);
        idle_pct = 17;

        // extreme peak settings: zero peaks, maxima, unordered, widely spaced, then the reset values
        set_peaks('0, '0, '0, '0, '0, '0);
        for (int i = 0; i < 8; i++) random_event(65535);
        set_peaks('1, '1, '1, '1, '1, '1);
        for (int i = 0; i < 8; i++) random_event(65535);
        set_peaks(20'd9000, 20'd3000, 20'd20000, 20'd100, 20'd50, 20'd900);
        for (int i = 0; i < 15; i++) random_event(6000);
        set_peaks(20'd1, 20'd2, 20'd300000, 20'd1, 20'd200000, 20'd1048575);
        for (int i = 0; i < 10; i++) random_event(65535);
        set_peaks(20'd4000, 20'd8000, 20'd12000, 20'd1600, 20'd3200, 20'd4800);
        write_reg(REG_UNUSED, '1);
        for (int i = 0; i < 40; i++) random_event(6000);

        drain_results();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

>>> files.f
design/eecc_pkg.sv
design/eecc_ctrl.sv
design/eecc_datapath.sv
design/event_electron_count_combiner_top.sv
tb/sv/eecc_checker.sv
tb/sv/tb_top.sv
